// ----- src/stick_radial_dead_zone_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef STICK_RADIAL_DEAD_ZONE_ASSERT_SVH
`define STICK_RADIAL_DEAD_ZONE_ASSERT_SVH

// Assertion that is muted while reset is asserted.
`define SRDZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also checks the cycles around reset.
`define SRDZ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/srdz_pkg.sv -----
package srdz_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 17;
  localparam int OUT_FRAC_BITS_DEF = 15;

  localparam int DZ_W   = 15;
  localparam int MV_W   = 16;
  localparam int OUT_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(8000);
  localparam logic [MV_W-1:0] MV_RESET = MV_W'(30000);

  // Register index, taken from paddr bit 2.
  localparam logic REG_DEAD_ZONE = 1'b0;
  localparam logic REG_MAX_VALUE = 1'b1;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QLW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [DZ_W-1:0] dead_zone;
    logic [MV_W-1:0] max_value;
  } cfg_t;

  typedef struct packed {
    logic           empty;
    logic [QLW-1:0] level;
  } q_stat_t;

endpackage

// ----- src/srdz_fifo.sv -----
module srdz_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     head_data,
  output srdz_pkg::q_stat_t    stat
);
  import srdz_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  logic [WIDTH-1:0] mem_r [QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QLW-1:0]   level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    level_nxt  = level_r + QLW'(push) - QLW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

endmodule

// ----- src/srdz_front.sv -----
module srdz_front #(
  parameter int SAMPLE_WIDTH = srdz_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] raw_x,
  input  logic signed [SAMPLE_WIDTH-1:0] raw_y,
  input  srdz_pkg::cfg_t                 cfg,
  input  srdz_pkg::q_stat_t              q_stat,
  output logic                           push,
  output logic [4*SAMPLE_WIDTH+2:0]      push_data
);
  import srdz_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int L2W = 2 * SW;
  localparam int CW  = (L2W > 2 * DZ_W) ? L2W : 2 * DZ_W;

  logic          a_vld_r;
  logic [SW-1:0] ax_r, ay_r;
  logic          nx_r, ny_r;

  logic          accept;
  logic [L2W-1:0] len2;
  logic [CW-1:0]  dz_sq;
  logic           zero;

  assign busy   = ({1'b0, q_stat.level} + (QLW + 1)'(a_vld_r)) >= (QLW + 1)'(QDEPTH);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
  end

  // Sign and magnitude; the most negative sample has a magnitude that still fits.
  always_ff @(posedge clk) begin
    if (accept) begin
      nx_r <= raw_x[SW-1];
      ny_r <= raw_y[SW-1];
      ax_r <= raw_x[SW-1] ? SW'(-raw_x) : SW'(raw_x);
      ay_r <= raw_y[SW-1] ? SW'(-raw_y) : SW'(raw_y);
    end
  end

  always_comb begin
    len2  = L2W'(ax_r * ax_r) + L2W'(ay_r * ay_r);
    dz_sq = CW'(cfg.dead_zone * cfg.dead_zone);
    zero  = (CW'(len2) < dz_sq) || (len2 == '0);
  end

  assign push      = a_vld_r;
  assign push_data = {zero, nx_r, ny_r, ax_r, ay_r, len2};

endmodule

// ----- src/srdz_back.sv -----
module srdz_back #(
  parameter int SAMPLE_WIDTH  = srdz_pkg::SAMPLE_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = srdz_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srdz_pkg::cfg_t                    cfg,
  input  srdz_pkg::q_stat_t                 q_stat,
  input  logic [4*SAMPLE_WIDTH+2:0]         head_data,
  output logic                              pop,
  output logic                              out_valid,
  output logic signed [srdz_pkg::OUT_W-1:0] out_x,
  output logic signed [srdz_pkg::OUT_W-1:0] out_y
);
  import srdz_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int F     = OUT_FRAC_BITS;
  localparam int L2W   = 2 * SW;
  localparam int PW    = SW + MV_W;
  localparam int QW    = F + 2;
  localparam int NW    = (SW > MV_W) ? SW : MV_W;
  localparam int XW    = (F + 3 > OUT_W) ? F + 3 : OUT_W;
  localparam int MAXS  = (SW > QW) ? SW : QW;
  localparam int CNTW  = $clog2(MAXS + 2);
  localparam logic [CNTW-1:0] SQ_STEPS  = CNTW'(SW);
  localparam logic [CNTW-1:0] DIV_STEPS = CNTW'(QW);
  localparam logic [XW-1:0]   TOP       = XW'((64'd1 << F) - 64'd1);

  typedef enum logic [2:0] {ST_IDLE, ST_SQRT, ST_MUL, ST_DIV, ST_FIN} state_t;

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]   ax_r, ay_r, ax_nxt, ay_nxt;
  logic            nx_r, ny_r, nx_nxt, ny_nxt;
  logic [L2W-1:0]  n_r, res_r, bit_r, n_nxt, res_nxt, bit_nxt;
  logic [PW-1:0]   d_r, d_nxt;
  logic [PW:0]     remx_r, remy_r, remx_nxt, remy_nxt;
  logic [QW-1:0]   qx_r, qy_r, qx_nxt, qy_nxt;
  logic            ov_r, ov_nxt;
  logic [OUT_W-1:0] ox_r, oy_r, ox_nxt, oy_nxt;

  logic            h_zero, h_nx, h_ny;
  logic [SW-1:0]   h_ax, h_ay;
  logic [L2W-1:0]  h_len2;
  logic [L2W:0]    t;
  logic [SW-1:0]   len;
  logic [MV_W-1:0] den, num;
  logic [NW-1:0]   diff;

  assign {h_zero, h_nx, h_ny, h_ax, h_ay, h_len2} = head_data;
  assign pop = (state_r == ST_IDLE) && !q_stat.empty;
  assign len = res_r[SW-1:0];

  function automatic logic [OUT_W-1:0] finish(input logic [QW-1:0] q, input logic neg);
    logic [XW-1:0] r;
    logic [XW-1:0] v;
    r = XW'((XW'(q) + XW'(1)) >> 1);
    if (neg) begin
      v = XW'(0) - r;
    end else begin
      v = (r > TOP) ? TOP : r;
    end
    return v[OUT_W-1:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ax_nxt = ax_r; ay_nxt = ay_r; nx_nxt = nx_r; ny_nxt = ny_r;
    n_nxt = n_r; res_nxt = res_r; bit_nxt = bit_r;
    d_nxt = d_r; remx_nxt = remx_r; remy_nxt = remy_r;
    qx_nxt = qx_r; qy_nxt = qy_r;
    ov_nxt = 1'b0; ox_nxt = ox_r; oy_nxt = oy_r;
    t = '0; den = '0; num = '0; diff = '0;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          ax_nxt = h_ax; ay_nxt = h_ay; nx_nxt = h_nx; ny_nxt = h_ny;
          if (h_zero) begin
            ov_nxt = 1'b1;
            ox_nxt = '0;
            oy_nxt = '0;
          end else begin
            n_nxt     = h_len2;
            res_nxt   = '0;
            bit_nxt   = L2W'(1) << (L2W - 2);
            cnt_nxt   = '0;
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        // Two bits of the root per cycle.
        for (int i = 0; i < 2; i++) begin
          if (cnt_nxt < SQ_STEPS) begin
            t = {1'b0, res_nxt} + {1'b0, bit_nxt};
            if ({1'b0, n_nxt} >= t) begin
              n_nxt   = n_nxt - t[L2W-1:0];
              res_nxt = (res_nxt >> 1) + bit_nxt;
            end else begin
              res_nxt = res_nxt >> 1;
            end
            bit_nxt = bit_nxt >> 2;
            cnt_nxt = cnt_nxt + CNTW'(1);
          end
        end
        if (cnt_nxt >= SQ_STEPS) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cfg.max_value <= MV_W'(cfg.dead_zone)) begin
          den = MV_W'(1);
          num = MV_W'(1);
        end else begin
          den  = cfg.max_value - MV_W'(cfg.dead_zone);
          diff = NW'(len) - NW'(cfg.dead_zone);
          num  = (diff > NW'(den)) ? den : diff[MV_W-1:0];
        end
        d_nxt     = PW'(len * den);
        remx_nxt  = (PW + 1)'(ax_r * num);
        remy_nxt  = (PW + 1)'(ay_r * num);
        qx_nxt    = '0;
        qy_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Two quotient bits per cycle for both axes; the first step has no shift.
        for (int i = 0; i < 2; i++) begin
          if (cnt_nxt < DIV_STEPS) begin
            if (cnt_nxt != '0) begin
              remx_nxt = remx_nxt << 1;
              remy_nxt = remy_nxt << 1;
            end
            qx_nxt = qx_nxt << 1;
            qy_nxt = qy_nxt << 1;
            if (remx_nxt >= {1'b0, d_r}) begin
              remx_nxt  = remx_nxt - {1'b0, d_r};
              qx_nxt[0] = 1'b1;
            end
            if (remy_nxt >= {1'b0, d_r}) begin
              remy_nxt  = remy_nxt - {1'b0, d_r};
              qy_nxt[0] = 1'b1;
            end
            cnt_nxt = cnt_nxt + CNTW'(1);
          end
        end
        if (cnt_nxt >= DIV_STEPS) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        ov_nxt    = 1'b1;
        ox_nxt    = finish(qx_r, nx_r);
        oy_nxt    = finish(qy_r, ny_r);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
    end
    ax_r <= ax_nxt; ay_r <= ay_nxt; nx_r <= nx_nxt; ny_r <= ny_nxt;
    n_r <= n_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
    d_r <= d_nxt; remx_r <= remx_nxt; remy_r <= remy_nxt;
    qx_r <= qx_nxt; qy_r <= qy_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt;
  end

  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;

endmodule

// ----- src/stick_radial_dead_zone.sv -----
// Scaled radial dead zone for one analog-stick sample pair. Raise start with
// in_raw_x and in_raw_y while busy is low and the item is taken at that clock
// edge. Each item gives exactly one result, shown on out_x and out_y for one
// cycle with out_valid high; the receiver cannot stall, so results must be
// taken as they come. The back end answers a sample inside the dead zone
// straight from its idle state as it pops it; any other sample is popped,
// then passes through an iterative square root, a multiply step, the
// two-bit-per-cycle divider shared by both axes and a final rounding step.
// The front end squares and classifies items and stores up to four of them in
// a queue, so a burst of items is taken one per cycle until the queue fills.
// dead_zone lies at address 0 and max_value at address 4 of the configuration
// port; write them only while no item is in flight.
module stick_radial_dead_zone #(
  parameter int SAMPLE_WIDTH  = srdz_pkg::SAMPLE_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = srdz_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_raw_x,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_raw_y,
  output logic                               out_valid,
  output logic signed [srdz_pkg::OUT_W-1:0]  out_x,
  output logic signed [srdz_pkg::OUT_W-1:0]  out_y,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srdz_pkg::ADDR_W-1:0]        paddr,
  input  logic [srdz_pkg::DATA_W-1:0]        pwdata,
  output logic [srdz_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import srdz_pkg::*;

  localparam int QIW = 4 * SAMPLE_WIDTH + 3;

  logic [DZ_W-1:0] dz_r;
  logic [MV_W-1:0] mv_r;
  cfg_t            cfg;
  q_stat_t         q_stat;
  logic            push, pop, wr;
  logic [QIW-1:0]  push_data, head_data;

  // Registers are word aligned; bit 2 of the address picks the register.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
      mv_r <= MV_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_DEAD_ZONE: dz_r <= pwdata[DZ_W-1:0];
        REG_MAX_VALUE: mv_r <= pwdata[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEAD_ZONE: prdata = DATA_W'(dz_r);
      REG_MAX_VALUE: prdata = DATA_W'(mv_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.dead_zone = dz_r;
  assign cfg.max_value = mv_r;

  srdz_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .raw_x     (in_raw_x),
    .raw_y     (in_raw_y),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  srdz_fifo #(.WIDTH(QIW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .stat      (q_stat)
  );

  srdz_back #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .head_data (head_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y)
  );

endmodule

// ----- src/srdz_chk.sv -----
`include "stick_radial_dead_zone_assert.svh"

module srdz_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import srdz_pkg::*;

  localparam int MAXF = QDEPTH + 2;
  localparam int CW   = $clog2(MAXF + 2);

  logic [CW-1:0] cnt_r;

  // Items taken but not yet answered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CW'(start && !busy) - CW'(out_valid);
    end
  end

  `SRDZ_ASSERT(a_no_orphan, out_valid |-> (cnt_r != '0), "result without an item")
  `SRDZ_ASSERT(a_bounded, cnt_r <= CW'(MAXF), "too many items in flight")
  `SRDZ_ASSERT_RST(a_reset, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule

bind stick_radial_dead_zone srdz_chk u_srdz_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
